FILE: rtl/core/mfsp_pkg.sv
`timescale 1ns / 1ps

package mfsp_pkg;

  localparam int BOUNDARY_MAX = 32;
  localparam int HELD_DEPTH   = BOUNDARY_MAX + 8;
  localparam int HELD_AW      = $clog2(HELD_DEPTH);
  localparam int MATCH_W      = 6;
  localparam int TOKEN_BYTES  = 32;
  localparam int TOKEN_W      = TOKEN_BYTES * 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_AW       = $clog2(CMD_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_BND_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BND_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BND_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BND_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BND_LEN    = 3'd4;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef enum logic [3:0] {
    K_PAY, K_NAMEB, K_VALB, K_BEGIN, K_NAMEEND,
    K_VALEND, K_HDREND, K_PARTEND, K_FINAL, K_ERR
  } kind_t;

  typedef enum logic [3:0] {
    PH_OPEN, PH_NAME, PH_VSTART, PH_VALUE, PH_VLF,
    PH_HLF, PH_PAYLOAD, PH_END, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {F_RUN, F_SECOND, F_DRAIN} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_RD, B_WR} back_state_t;

  typedef struct packed {
    logic               is_drain;
    kind_t              kind;
    logic [7:0]         data;
    logic [31:0]        off;
    logic               fin;
    logic               last;
    logic [MATCH_W-1:0] count;
  } cmd_t;

  function automatic cmd_t mk_emit(input kind_t k, input logic [7:0] d,
                                   input logic [31:0] o, input logic f,
                                   input logic l);
    cmd_t c;
    c          = '0;
    c.kind     = k;
    c.data     = d;
    c.off      = o;
    c.fin      = f;
    c.last     = l;
    return c;
  endfunction

  // HTTP token characters: printable ASCII minus the separators.
  function automatic logic tchar_ok(input logic [7:0] b);
    logic ok;
    ok = (b >= 8'd33) && (b <= 8'd126);
    unique case (b)
      8'd34, 8'd40, 8'd41, 8'd44, 8'd47, 8'd58, 8'd59, 8'd60, 8'd61,
      8'd62, 8'd63, 8'd64, 8'd91, 8'd92, 8'd93, 8'd123, 8'd125: ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

  function automatic logic [MATCH_W-1:0] token_len(input logic [5:0] blen);
    logic [MATCH_W-1:0] n;
    n = blen;
    if (n == '0) n = MATCH_W'(1);
    if (n > MATCH_W'(BOUNDARY_MAX)) n = MATCH_W'(BOUNDARY_MAX);
    return n;
  endfunction

  // Delimiter pattern: CR LF dash dash token.
  function automatic logic [7:0] pattern_byte(input logic [MATCH_W-1:0] i,
                                              input logic [TOKEN_W-1:0] tok);
    logic [MATCH_W-1:0] k;
    logic [7:0]         r;
    k = i - MATCH_W'(4);
    if (i == MATCH_W'(0)) r = CH_CR;
    else if (i == MATCH_W'(1)) r = CH_LF;
    else if (i < MATCH_W'(4)) r = CH_DASH;
    else if (k >= MATCH_W'(TOKEN_BYTES)) r = 8'd0;
    else r = tok[k[4:0]*8 +: 8];
    return r;
  endfunction

endpackage

FILE: rtl/core/mfsp_ram.sv
`timescale 1ns / 1ps

module mfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mfsp_cmd_fifo.sv
`timescale 1ns / 1ps

module mfsp_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mfsp_pkg::cmd_t  wdata,
  input  logic            pop,
  output mfsp_pkg::cmd_t  rdata,
  output logic            empty,
  output logic            full
);
  import mfsp_pkg::*;

  cmd_t              q_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMD_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + CMD_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + CMD_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (CMD_AW+1)'(push) - (CMD_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= wdata;
  end

  assign rdata = q_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));

endmodule

FILE: rtl/core/mfsp_front.sv
`timescale 1ns / 1ps

module mfsp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [7:0]                         in_data_byte,
  input  logic                               cfg_we,
  input  logic [mfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               push,
  output mfsp_pkg::cmd_t                     push_data,
  input  logic                               fifo_full,
  input  logic                               back_idle,
  output logic                               ram_we,
  output logic [mfsp_pkg::HELD_AW-1:0]       ram_waddr,
  output logic [7:0]                         ram_wdata
);
  import mfsp_pkg::*;

  logic [CFG_DATA_W-1:0] tok_r [4];
  logic [5:0]            blen_r;
  logic [TOKEN_W-1:0]    token;

  front_state_t       fs_r, fs_nxt;
  phase_t             phase_r, phase_nxt, phase_d;
  logic [MATCH_W-1:0] match_r, match_nxt, match_d;
  logic               final_r, final_nxt, final_d;
  logic [31:0]        off_r, off_nxt, off_d;
  logic               name_r, name_nxt, name_d;
  logic [7:0]         tail_r, tail_nxt;
  cmd_t               pend_r, pend_nxt;

  logic [1:0]         d_npush;
  cmd_t               d_a, d_b;
  logic               d_drain, d_we;
  logic [MATCH_W-1:0] d_waddr;
  logic               accept;

  logic [7:0]         b;
  logic [MATCH_W-1:0] n;
  logic [MATCH_W:0]   m7, n7, plen7;
  logic               adv, done;

  assign token  = {tok_r[3], tok_r[2], tok_r[1], tok_r[0]};
  assign b      = in_data_byte;
  assign accept = in_valid && !in_stall;

  // Classify one byte against the parse state.
  always_comb begin
    d_npush = 2'd0;
    d_a     = '0;
    d_b     = '0;
    d_drain = 1'b0;
    d_we    = 1'b0;
    d_waddr = '0;
    phase_d = phase_r;
    match_d = match_r;
    final_d = final_r;
    off_d   = off_r;
    name_d  = name_r;
    adv     = 1'b0;
    done    = 1'b0;
    n       = token_len(blen_r);
    n7      = {1'b0, n};
    m7      = {1'b0, match_r};
    plen7   = n7 + (MATCH_W+1)'(4);
    if (in_op) begin
      phase_d = PH_OPEN;
      match_d = '0;
      final_d = 1'b0;
      off_d   = '0;
      name_d  = 1'b0;
    end else begin
      unique case (phase_r)
        PH_OPEN: begin
          if (m7 < n7 + (MATCH_W+1)'(2)) begin
            if (b != pattern_byte(match_r + MATCH_W'(2), token)) begin
              d_npush = 2'd1;
              d_a     = mk_emit(K_ERR, 8'd0, 32'd0, 1'b0, 1'b1);
              phase_d = PH_ERROR;
            end else begin
              match_d = match_r + MATCH_W'(1);
            end
          end else if (m7 == n7 + (MATCH_W+1)'(2) && b == CH_CR) begin
            match_d = match_r + MATCH_W'(1);
          end else if (m7 == n7 + (MATCH_W+1)'(3) && b == CH_LF) begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_BEGIN, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_NAME;
            name_d  = 1'b0;
            match_d = '0;
          end else begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_ERR, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_ERROR;
          end
        end
        PH_NAME: begin
          if (b == CH_CR) begin
            phase_d = PH_HLF;
          end else if (b == CH_COLON && name_r) begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_NAMEEND, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_VSTART;
          end else if (b != CH_COLON && tchar_ok(b)) begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_NAMEB, b, 32'd0, 1'b0, 1'b1);
            name_d  = 1'b1;
          end else begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_ERR, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_ERROR;
          end
        end
        PH_VSTART, PH_VALUE: begin
          if (!(phase_r == PH_VSTART && b == CH_SPACE)) begin
            d_npush = 2'd1;
            if (b == CH_CR) begin
              d_a     = mk_emit(K_VALEND, 8'd0, 32'd0, 1'b0, 1'b1);
              phase_d = PH_VLF;
            end else begin
              d_a     = mk_emit(K_VALB, b, 32'd0, 1'b0, 1'b1);
              phase_d = PH_VALUE;
            end
          end
        end
        PH_VLF: begin
          if (b != CH_LF) begin
            d_npush = 2'd1;
            d_a     = mk_emit(K_ERR, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_ERROR;
          end else begin
            phase_d = PH_NAME;
            name_d  = 1'b0;
            match_d = '0;
          end
        end
        PH_HLF: begin
          d_npush = 2'd1;
          if (b != CH_LF) begin
            d_a     = mk_emit(K_ERR, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_ERROR;
          end else begin
            d_a     = mk_emit(K_HDREND, 8'd0, 32'd0, 1'b0, 1'b1);
            phase_d = PH_PAYLOAD;
            off_d   = '0;
            match_d = '0;
            final_d = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          if (match_r == '0) begin
            if (b == CH_CR) begin
              d_we    = 1'b1;
              match_d = MATCH_W'(1);
            end else begin
              d_npush = 2'd1;
              d_a     = mk_emit(K_PAY, b, off_r, 1'b0, 1'b1);
              off_d   = off_r + 32'd1;
            end
          end else begin
            if (m7 < plen7) begin
              adv = (b == pattern_byte(match_r, token));
            end else if (m7 == plen7) begin
              if (b == CH_CR) begin
                adv     = 1'b1;
                final_d = 1'b0;
              end else if (b == CH_DASH) begin
                adv     = 1'b1;
                final_d = 1'b1;
              end
            end else if (m7 == plen7 + (MATCH_W+1)'(1)) begin
              if (!final_r && b == CH_LF) begin
                done    = 1'b1;
                d_npush = 2'd2;
                d_a     = mk_emit(K_PARTEND, 8'd0, 32'd0, 1'b0, 1'b0);
                d_b     = mk_emit(K_BEGIN, 8'd0, 32'd0, 1'b0, 1'b1);
                off_d   = '0;
                phase_d = PH_NAME;
                name_d  = 1'b0;
                match_d = '0;
              end else begin
                adv = final_r && b == CH_DASH;
              end
            end else if (m7 == plen7 + (MATCH_W+1)'(2)) begin
              adv = final_r && b == CH_CR;
            end else if (m7 == plen7 + (MATCH_W+1)'(3)) begin
              if (final_r && b == CH_LF) begin
                done    = 1'b1;
                d_npush = 2'd2;
                d_a     = mk_emit(K_PARTEND, 8'd0, 32'd0, 1'b1, 1'b0);
                d_b     = mk_emit(K_FINAL, 8'd0, 32'd0, 1'b1, 1'b1);
                match_d = '0;
                phase_d = PH_END;
              end
            end
            if (!done) begin
              if (adv && m7 < (MATCH_W+1)'(HELD_DEPTH)) begin
                d_we    = 1'b1;
                d_waddr = match_r;
                match_d = match_r + MATCH_W'(1);
              end else begin
                // Mismatch: the held bytes go out as payload first.
                d_npush        = 2'd1;
                d_drain        = 1'b1;
                d_a            = '0;
                d_a.is_drain   = 1'b1;
                d_a.kind       = K_PAY;
                d_a.off        = off_r;
                d_a.count      = match_r;
                d_a.last       = (b == CH_CR);
                off_d          = off_r + 32'(match_r);
                match_d        = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fs_nxt = fs_r;
    unique case (fs_r)
      F_RUN: begin
        if (accept && d_npush == 2'd2) fs_nxt = F_SECOND;
        else if (accept && d_drain) fs_nxt = F_DRAIN;
      end
      F_SECOND: if (!fifo_full) fs_nxt = F_RUN;
      F_DRAIN:  if (back_idle) fs_nxt = F_RUN;
      default:  fs_nxt = F_RUN;
    endcase
  end

  always_comb begin
    in_stall  = !(fs_r == F_RUN && !fifo_full);
    push      = 1'b0;
    push_data = d_a;
    ram_we    = 1'b0;
    ram_waddr = HELD_AW'(d_waddr);
    ram_wdata = b;
    phase_nxt = phase_r;
    match_nxt = match_r;
    final_nxt = final_r;
    off_nxt   = off_r;
    name_nxt  = name_r;
    tail_nxt  = tail_r;
    pend_nxt  = pend_r;
    unique case (fs_r)
      F_RUN: begin
        if (accept) begin
          push      = (d_npush != 2'd0);
          ram_we    = d_we;
          phase_nxt = phase_d;
          match_nxt = match_d;
          final_nxt = final_d;
          off_nxt   = off_d;
          name_nxt  = name_d;
          tail_nxt  = b;
          pend_nxt  = d_b;
        end
      end
      F_SECOND: begin
        push_data = pend_r;
        push      = !fifo_full;
      end
      F_DRAIN: begin
        // Tail byte waits until every held byte has been read out.
        push_data = mk_emit(K_PAY, tail_r, off_r, 1'b0, 1'b1);
        ram_waddr = '0;
        ram_wdata = tail_r;
        if (back_idle) begin
          if (tail_r == CH_CR) begin
            ram_we    = 1'b1;
            match_nxt = MATCH_W'(1);
          end else begin
            push    = 1'b1;
            off_nxt = off_r + 32'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r    <= F_RUN;
      phase_r <= PH_OPEN;
      match_r <= '0;
      final_r <= 1'b0;
      off_r   <= '0;
      name_r  <= 1'b0;
      tok_r   <= '{default: '0};
      blen_r  <= 6'd1;
    end else begin
      fs_r    <= fs_nxt;
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      final_r <= final_nxt;
      off_r   <= off_nxt;
      name_r  <= name_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BND_LO:     tok_r[0] <= cfg_data;
          REG_BND_MID_LO: tok_r[1] <= cfg_data;
          REG_BND_MID_HI: tok_r[2] <= cfg_data;
          REG_BND_HI:     tok_r[3] <= cfg_data;
          REG_BND_LEN:    blen_r   <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
    tail_r <= tail_nxt;
    pend_r <= pend_nxt;
  end

endmodule

FILE: rtl/core/mfsp_back.sv
`timescale 1ns / 1ps

module mfsp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  mfsp_pkg::cmd_t                fifo_rdata,
  output logic                          fifo_pop,
  output logic                          back_idle,
  output logic                          ram_re,
  output logic [mfsp_pkg::HELD_AW-1:0]  ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_kind,
  output logic [7:0]                    out_out_byte,
  output logic [31:0]                   out_content_offset,
  output logic                          out_final_part,
  output logic                          out_last
);
  import mfsp_pkg::*;

  back_state_t        bs_r, bs_nxt;
  logic [MATCH_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [31:0]        base_r, base_nxt;
  logic               dlast_r, dlast_nxt;
  logic               ov_r, ov_nxt;
  cmd_t               o_r, o_nxt;
  logic               slot_free, drain_done;

  assign slot_free  = !ov_r || !out_stall;
  assign drain_done = (idx_r + MATCH_W'(1) == cnt_r);

  always_comb begin
    bs_nxt = bs_r;
    unique case (bs_r)
      B_IDLE: if (!fifo_empty && fifo_rdata.is_drain) bs_nxt = B_RD;
      B_RD:   bs_nxt = B_WR;
      B_WR:   if (slot_free) bs_nxt = drain_done ? B_IDLE : B_RD;
      default: bs_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = HELD_AW'(idx_r);
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    dlast_nxt = dlast_r;
    ov_nxt    = ov_r && out_stall;
    o_nxt     = o_r;
    unique case (bs_r)
      B_IDLE: begin
        if (!fifo_empty && (fifo_rdata.is_drain || slot_free)) begin
          fifo_pop = 1'b1;
          if (fifo_rdata.is_drain) begin
            cnt_nxt   = fifo_rdata.count;
            base_nxt  = fifo_rdata.off;
            dlast_nxt = fifo_rdata.last;
            idx_nxt   = '0;
          end else begin
            ov_nxt = 1'b1;
            o_nxt  = fifo_rdata;
          end
        end
      end
      B_RD: ram_re = 1'b1;
      B_WR: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          o_nxt  = mk_emit(K_PAY, ram_rdata, base_r + 32'(idx_r), 1'b0,
                           dlast_r && drain_done);
          idx_nxt = idx_r + MATCH_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      bs_r <= bs_nxt;
      ov_r <= ov_nxt;
    end
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    base_r  <= base_nxt;
    dlast_r <= dlast_nxt;
    o_r     <= o_nxt;
  end

  assign back_idle          = (bs_r == B_IDLE) && fifo_empty;
  assign out_valid          = ov_r;
  assign out_kind           = o_r.kind;
  assign out_out_byte       = o_r.data;
  assign out_content_offset = o_r.off;
  assign out_final_part     = o_r.fin;
  assign out_last           = o_r.last;

endmodule

FILE: rtl/core/multipart_form_stream_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_op, in_data_byte
// out_      output     out_valid/out_stall  out_kind, out_out_byte, out_content_offset,
//                                           out_final_part, out_last
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// An ordinary byte produces at most one result directly.
// A byte that closes a part produces two results and holds the input until the second is queued.
// A delimiter mismatch releases up to 39 held bytes from the held-byte RAM through its
// single read port, and the input stalls until that drain is done.
// Reset is synchronous and active low; the held-byte RAM is not cleared.
// An output stall holds a drain and fills the command queue; input stalls once it is full.

module multipart_form_stream_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         out_kind,
  output logic [7:0]                         out_out_byte,
  output logic [31:0]                        out_content_offset,
  output logic                               out_final_part,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [mfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mfsp_pkg::*;

  // Front to back: each queued transaction is either one finished result or a drain request.
  cmd_t               push_data, pop_data;
  logic               push, pop, fifo_empty, fifo_full, back_idle;
  logic               ram_we, ram_re;
  logic [HELD_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  mfsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_data    (push_data),
    .fifo_full    (fifo_full),
    .back_idle    (back_idle),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  mfsp_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (pop_data),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  // The held candidate delimiter bytes live here.
  mfsp_ram #(
    .WIDTH (8),
    .DEPTH (HELD_DEPTH)
  ) u_held (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mfsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fifo_empty         (fifo_empty),
    .fifo_rdata         (pop_data),
    .fifo_pop           (pop),
    .back_idle          (back_idle),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_out_byte       (out_out_byte),
    .out_content_offset (out_content_offset),
    .out_final_part     (out_final_part),
    .out_last           (out_last)
  );

endmodule
